FILE: rtl/latency_stats_histogram_assert.svh
// ============================================================================
// latency_stats_histogram assertion macros
// Concurrent assertion wrappers; they expand to nothing in synthesis.
// ============================================================================
`ifndef LATENCY_STATS_HISTOGRAM_ASSERT_SVH
`define LATENCY_STATS_HISTOGRAM_ASSERT_SVH

`ifndef SYNTHESIS
// Check a property on every rising edge outside of reset.
`define LSH_ASSERT(lbl, clk, rst_n, prop, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);
// Check a property on every rising edge, reset included.
`define LSH_ASSERT_ALWAYS(lbl, clk, prop, msg) \
    lbl: assert property (@(posedge clk) prop) else $error(msg);
`else
`define LSH_ASSERT(lbl, clk, rst_n, prop, msg)
`define LSH_ASSERT_ALWAYS(lbl, clk, prop, msg)
`endif

`endif

FILE: rtl/lsh_pkg.sv
`timescale 1ns / 1ps
// ============================================================================
// lsh_pkg
// Shared constants, codes and controller/datapath interface types.
// ============================================================================
package lsh_pkg;

    localparam int HIST_DEPTH = 8192;
    localparam int BIN_COUNT  = 10;

    localparam int SAMPLE_W   = 31;
    localparam int SUM_W      = 44;
    localparam int ADDR_W     = $clog2(HIST_DEPTH);
    localparam int CNT_W      = $clog2(HIST_DEPTH + 1);
    localparam int TALLY_W    = 14;
    localparam int BIN_NUM_W  = 4;
    localparam int STATUS_W   = 2;
    localparam int BIN_IDX_W  = $clog2(BIN_COUNT);
    localparam int EMIT_W     = $clog2(BIN_COUNT + 1);
    localparam int SEQ_W      = (CNT_W > EMIT_W) ? CNT_W : EMIT_W;

    // Mean divider operand widths
    localparam int DIV_W      = SUM_W;
    localparam int DVS_W      = (CNT_W > EMIT_W) ? CNT_W : EMIT_W;

    // Bin width by reciprocal multiplication: span * RECIP >> SHIFT is exact
    // for every span below 2**SAMPLE_W.
    localparam int WIDTH_SHIFT = SAMPLE_W + $clog2(BIN_COUNT);
    localparam int RECIP_W     = SAMPLE_W + 1;
    localparam int PROD_W      = SAMPLE_W + RECIP_W;
    localparam logic [RECIP_W-1:0] WIDTH_RECIP =
        RECIP_W'(((64'd1 << WIDTH_SHIFT) + BIN_COUNT - 1) / BIN_COUNT);

    // Request codes
    localparam logic REQ_RECORD = 1'b0;
    localparam logic REQ_REPORT = 1'b1;

    // Result item kinds
    localparam logic KIND_SUMMARY = 1'b0;
    localparam logic KIND_BIN     = 1'b1;

    // Report status codes
    localparam logic [STATUS_W-1:0] ST_OK      = 2'd0;
    localparam logic [STATUS_W-1:0] ST_EMPTY   = 2'd1;
    localparam logic [STATUS_W-1:0] ST_DROPPED = 2'd2;

    typedef struct packed {
        logic                 rec;
        logic                 rpt_begin;
        logic                 div_start;
        logic                 mean_cap;
        logic                 width_cap;
        logic                 edge_en;
        logic [BIN_IDX_W-1:0] edge_idx;
        logic                 scan_en;
        logic [ADDR_W-1:0]    scan_addr;
        logic [EMIT_W-1:0]    emit_idx;
        logic                 clear;
    } t_dp_cmd;

    typedef struct packed {
        logic             div_done;
        logic [CNT_W-1:0] count;
    } t_dp_sts;

endpackage

FILE: rtl/lsh_ram.sv
`timescale 1ns / 1ps
// ============================================================================
// lsh_ram
// Simple dual-port RAM: one write port, one read port with registered data.
// ============================================================================
module lsh_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 1024
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic                     i_re,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

FILE: rtl/lsh_div.sv
`timescale 1ns / 1ps
// ============================================================================
// lsh_div
// Restoring divider, one quotient bit per cycle.
// ============================================================================
module lsh_div (
    input  logic                      i_clk,
    input  logic                      i_rst_n,
    input  logic                      i_start,
    input  logic [lsh_pkg::DIV_W-1:0] i_dividend,
    input  logic [lsh_pkg::DVS_W-1:0] i_divisor,
    output logic                      o_done,
    output logic [lsh_pkg::DIV_W-1:0] o_quotient
);
    import lsh_pkg::*;

    localparam int ITER_W = $clog2(DIV_W);

    logic              r_busy;
    logic              r_done;
    logic [ITER_W-1:0] r_iter;
    logic [DIV_W-1:0]  r_dvd;
    logic [DVS_W-1:0]  r_dvs;
    logic [DVS_W-1:0]  r_rem;

    logic [DVS_W:0]    rem_sh;
    logic [DVS_W:0]    rem_sub;
    logic              q_bit;

    always_comb begin
        rem_sh  = {r_rem, r_dvd[DIV_W-1]};
        rem_sub = rem_sh - {1'b0, r_dvs};
        q_bit   = (rem_sh >= {1'b0, r_dvs});
    end

    // Control
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_iter <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_busy <= 1'b1;
                r_iter <= ITER_W'(DIV_W - 1);
            end else if (r_busy) begin
                r_iter <= r_iter - 1'b1;
                if (r_iter == '0) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    // Shift and subtract
    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_dvd <= i_dividend;
            r_dvs <= i_divisor;
            r_rem <= '0;
        end else if (r_busy) begin
            r_rem <= q_bit ? rem_sub[DVS_W-1:0] : rem_sh[DVS_W-1:0];
            r_dvd <= {r_dvd[DIV_W-2:0], q_bit};
        end
    end

    assign o_done     = r_done;
    assign o_quotient = r_dvd;

endmodule

FILE: rtl/lsh_dp.sv
`timescale 1ns / 1ps
// ============================================================================
// lsh_dp
// Statistics registers, sample history, bin edges, tallies and result fields.
// ============================================================================
module lsh_dp (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  lsh_pkg::t_dp_cmd              i_cmd,
    output lsh_pkg::t_dp_sts              o_sts,
    input  logic [lsh_pkg::SAMPLE_W-1:0]  i_sample_ns,
    output logic                          o_item_kind,
    output logic [lsh_pkg::BIN_NUM_W-1:0] o_bin_number,
    output logic [lsh_pkg::SAMPLE_W-1:0]  o_bin_low_ns,
    output logic [lsh_pkg::SAMPLE_W-1:0]  o_bin_high_ns,
    output logic [lsh_pkg::TALLY_W-1:0]   o_tally,
    output logic [lsh_pkg::SAMPLE_W-1:0]  o_mean_ns,
    output logic [lsh_pkg::SAMPLE_W-1:0]  o_max_ns,
    output logic [lsh_pkg::STATUS_W-1:0]  o_status,
    output logic                          o_last
);
    import lsh_pkg::*;

    // Running statistics
    logic [SUM_W-1:0]    r_sum;
    logic [CNT_W-1:0]    r_count;
    logic [SAMPLE_W-1:0] r_max;
    logic [SAMPLE_W-1:0] r_min;
    logic                r_dropped;

    // Report working registers
    logic [SAMPLE_W-1:0] r_mean;
    logic [SAMPLE_W-1:0] r_span;
    logic [SAMPLE_W-1:0] r_width;
    logic [SAMPLE_W-1:0] r_acc;
    logic [SAMPLE_W-1:0] r_lo [BIN_COUNT];
    logic [SAMPLE_W-1:0] r_hi [BIN_COUNT];
    logic [TALLY_W-1:0]  r_tally [BIN_COUNT];
    logic                r_rd_v;
    logic [BIN_COUNT-1:0] r_hit;

    logic                full;
    logic                hist_we;
    logic [SAMPLE_W-1:0] rd_sample;
    logic [BIN_COUNT-1:0] hit;
    logic [SAMPLE_W-1:0] n_acc;
    logic [PROD_W-1:0]   width_prod;
    logic                div_done;
    logic [DIV_W-1:0]    div_quot;
    logic                is_sum;
    logic [BIN_IDX_W-1:0] k;
    logic [STATUS_W-1:0] status;

    assign full    = (r_count == CNT_W'(HIST_DEPTH));
    assign hist_we = i_cmd.rec && !full;

    lsh_ram #(
        .WIDTH (SAMPLE_W),
        .DEPTH (HIST_DEPTH)
    ) u_hist (
        .i_clk   (i_clk),
        .i_we    (hist_we),
        .i_waddr (r_count[ADDR_W-1:0]),
        .i_wdata (i_sample_ns),
        .i_re    (i_cmd.scan_en),
        .i_raddr (i_cmd.scan_addr),
        .o_rdata (rd_sample)
    );

    lsh_div u_div (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_start    (i_cmd.div_start),
        .i_dividend (r_sum),
        .i_divisor  (DVS_W'(r_count)),
        .o_done     (div_done),
        .o_quotient (div_quot)
    );

    // Statistics update on record, clear after the final beat
    always_ff @(posedge i_clk) begin
        if (!i_rst_n || i_cmd.clear) begin
            r_sum     <= '0;
            r_count   <= '0;
            r_max     <= '0;
            r_min     <= '0;
            r_dropped <= 1'b0;
        end else if (i_cmd.rec) begin
            if (full) begin
                r_dropped <= 1'b1;
            end else begin
                r_sum   <= r_sum + SUM_W'(i_sample_ns);
                r_count <= r_count + 1'b1;
                if (i_sample_ns > r_max) begin
                    r_max <= i_sample_ns;
                end
                if (r_count == '0 || i_sample_ns < r_min) begin
                    r_min <= i_sample_ns;
                end
            end
        end
    end

    // Bin width: span / BIN_COUNT by reciprocal multiply on the held span
    assign width_prod = PROD_W'(r_span) * PROD_W'(WIDTH_RECIP);

    // Quotients and bin edges
    assign n_acc = r_acc + r_width;

    always_ff @(posedge i_clk) begin
        if (i_cmd.rpt_begin) begin
            r_span <= r_max - r_min;
        end
        if (i_cmd.mean_cap) begin
            r_mean <= div_quot[SAMPLE_W-1:0];
        end
        if (i_cmd.width_cap) begin
            r_width <= SAMPLE_W'(width_prod[PROD_W-1:WIDTH_SHIFT]);
            r_acc   <= r_min;
        end else if (i_cmd.edge_en) begin
            r_acc <= n_acc;
        end
        if (i_cmd.edge_en) begin
            r_lo[i_cmd.edge_idx] <= r_acc;
            r_hi[i_cmd.edge_idx] <= n_acc;
        end
    end

    // Bin match on the read sample; the maximum always lands in the last bin
    always_comb begin
        for (int j = 0; j < BIN_COUNT; j++) begin
            hit[j] = (rd_sample >= r_lo[j]) && (rd_sample < r_hi[j]);
        end
        hit[BIN_COUNT-1] = hit[BIN_COUNT-1] || (rd_sample == r_max);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_rd_v <= 1'b0;
            r_hit  <= '0;
        end else begin
            r_rd_v <= i_cmd.scan_en;
            r_hit  <= r_rd_v ? hit : '0;
        end
    end

    always_ff @(posedge i_clk) begin
        for (int j = 0; j < BIN_COUNT; j++) begin
            if (!i_rst_n || i_cmd.rpt_begin) begin
                r_tally[j] <= '0;
            end else if (r_hit[j]) begin
                r_tally[j] <= r_tally[j] + 1'b1;
            end
        end
    end

    // Result fields
    always_comb begin
        if (r_count == '0) begin
            status = ST_EMPTY;
        end else if (r_dropped) begin
            status = ST_DROPPED;
        end else begin
            status = ST_OK;
        end
    end

    assign is_sum = (i_cmd.emit_idx == '0);
    assign k      = BIN_IDX_W'(i_cmd.emit_idx - 1'b1);

    always_comb begin
        if (is_sum) begin
            o_item_kind   = KIND_SUMMARY;
            o_bin_number  = '0;
            o_bin_low_ns  = '0;
            o_bin_high_ns = '0;
            o_tally       = TALLY_W'(r_count);
            o_mean_ns     = (r_count == '0) ? '0 : r_mean;
            o_max_ns      = r_max;
        end else begin
            o_item_kind   = KIND_BIN;
            o_bin_number  = BIN_NUM_W'(k);
            o_bin_low_ns  = r_lo[k];
            o_bin_high_ns = r_hi[k];
            o_tally       = r_tally[k];
            o_mean_ns     = '0;
            o_max_ns      = '0;
        end
    end

    assign o_status = status;
    assign o_last   = (i_cmd.emit_idx == EMIT_W'(BIN_COUNT));

    assign o_sts.div_done = div_done;
    assign o_sts.count    = r_count;

endmodule

FILE: rtl/lsh_ctrl.sv
`timescale 1ns / 1ps
// ============================================================================
// lsh_ctrl
// Sequencer for record, report (divide, edges, scan, drain) and emission.
// ============================================================================
module lsh_ctrl (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_in_valid,
    output logic             o_in_ready,
    input  logic             i_req_type,
    output logic             o_out_valid,
    input  logic             i_out_ready,
    output lsh_pkg::t_dp_cmd o_cmd,
    input  lsh_pkg::t_dp_sts i_sts
);
    import lsh_pkg::*;

    localparam logic [2:0] S_IDLE  = 3'd0;
    localparam logic [2:0] S_MEAN  = 3'd1;
    localparam logic [2:0] S_EDGE  = 3'd3;
    localparam logic [2:0] S_SCAN  = 3'd4;
    localparam logic [2:0] S_DRAIN = 3'd5;
    localparam logic [2:0] S_EMIT  = 3'd6;

    logic [2:0]       r_state;
    logic [2:0]       n_state;
    logic [SEQ_W-1:0] r_cnt;
    logic [SEQ_W-1:0] n_cnt;
    logic             in_beat;

    assign in_beat = i_in_valid && o_in_ready;

    always_comb begin
        n_state     = r_state;
        n_cnt       = r_cnt;
        o_in_ready  = 1'b0;
        o_out_valid = 1'b0;
        o_cmd       = '0;
        o_cmd.edge_idx  = r_cnt[BIN_IDX_W-1:0];
        o_cmd.scan_addr = r_cnt[ADDR_W-1:0];
        o_cmd.emit_idx  = r_cnt[EMIT_W-1:0];

        case (r_state)
            S_IDLE: begin
                o_in_ready = 1'b1;
                if (in_beat) begin
                    if (i_req_type == REQ_RECORD) begin
                        o_cmd.rec = 1'b1;
                    end else begin
                        o_cmd.rpt_begin = 1'b1;
                        o_cmd.div_start = 1'b1;
                        n_state         = S_MEAN;
                    end
                end
            end
            S_MEAN: begin
                // bin width is ready from the multiplier by now
                if (i_sts.div_done) begin
                    o_cmd.mean_cap  = 1'b1;
                    o_cmd.width_cap = 1'b1;
                    n_cnt           = '0;
                    n_state         = S_EDGE;
                end
            end
            S_EDGE: begin
                o_cmd.edge_en = 1'b1;
                if (r_cnt == SEQ_W'(BIN_COUNT - 1)) begin
                    n_cnt   = '0;
                    n_state = S_SCAN;
                end else begin
                    n_cnt = r_cnt + 1'b1;
                end
            end
            S_SCAN: begin
                if (r_cnt == SEQ_W'(i_sts.count)) begin
                    n_cnt   = '0;
                    n_state = S_DRAIN;
                end else begin
                    o_cmd.scan_en = 1'b1;
                    n_cnt         = r_cnt + 1'b1;
                end
            end
            S_DRAIN: begin
                // wait out RAM read and tally update stages
                if (r_cnt == SEQ_W'(1)) begin
                    n_cnt   = '0;
                    n_state = S_EMIT;
                end else begin
                    n_cnt = r_cnt + 1'b1;
                end
            end
            S_EMIT: begin
                o_out_valid = 1'b1;
                if (i_out_ready) begin
                    if (r_cnt == SEQ_W'(BIN_COUNT)) begin
                        o_cmd.clear = 1'b1;
                        n_cnt       = '0;
                        n_state     = S_IDLE;
                    end else begin
                        n_cnt = r_cnt + 1'b1;
                    end
                end
            end
            default: begin
                n_cnt   = '0;
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_cnt   <= '0;
        end else begin
            r_state <= n_state;
            r_cnt   <= n_cnt;
        end
    end

endmodule

FILE: rtl/latency_stats_histogram.sv
`timescale 1ns / 1ps
// Record beat: accepted with no result; the next beat can follow at once.
// Report beat: a restoring division for the mean (bin width by reciprocal
//   multiply meanwhile), the bin edges, a scan of the recorded samples, a drain
//   of the RAM read and tally update stages, then 1 + BIN_COUNT result beats.
// Reset (synchronous, active low) clears statistics, tallies and control;
//   the history RAM is not cleared, only entries written since the last report are read.
// ============================================================================
// latency_stats_histogram
// Latency sample recorder with mean/max summary and equal-width histogram.
// ============================================================================
`include "latency_stats_histogram_assert.svh"

module latency_stats_histogram (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    // Request channel
    input  logic                          i_in_valid,
    output logic                          o_in_ready,
    input  logic                          i_req_type,
    input  logic [lsh_pkg::SAMPLE_W-1:0]  i_sample_ns,
    // Result channel
    output logic                          o_out_valid,
    input  logic                          i_out_ready,
    output logic                          o_item_kind,
    output logic [lsh_pkg::BIN_NUM_W-1:0] o_bin_number,
    output logic [lsh_pkg::SAMPLE_W-1:0]  o_bin_low_ns,
    output logic [lsh_pkg::SAMPLE_W-1:0]  o_bin_high_ns,
    output logic [lsh_pkg::TALLY_W-1:0]   o_tally,
    output logic [lsh_pkg::SAMPLE_W-1:0]  o_mean_ns,
    output logic [lsh_pkg::SAMPLE_W-1:0]  o_max_ns,
    output logic [lsh_pkg::STATUS_W-1:0]  o_status,
    output logic                          o_last
);
    import lsh_pkg::*;

    // Command and status between the sequencer and the datapath
    t_dp_cmd dp_cmd;
    t_dp_sts dp_sts;

    // Sequencer: takes request beats in idle, walks the report phases and
    // presents the result beats one per output handshake.
    lsh_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .o_in_ready  (o_in_ready),
        .i_req_type  (i_req_type),
        .o_out_valid (o_out_valid),
        .i_out_ready (i_out_ready),
        .o_cmd       (dp_cmd),
        .i_sts       (dp_sts)
    );

    // Datapath: running sum/count/min/max, history RAM, mean divider,
    // reciprocal multiply for the bin width, bin edge registers and per-bin
    // tally counters. Result fields are driven from registers and held while
    // the sequencer keeps the beat up.
    lsh_dp u_dp (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cmd         (dp_cmd),
        .o_sts         (dp_sts),
        .i_sample_ns   (i_sample_ns),
        .o_item_kind   (o_item_kind),
        .o_bin_number  (o_bin_number),
        .o_bin_low_ns  (o_bin_low_ns),
        .o_bin_high_ns (o_bin_high_ns),
        .o_tally       (o_tally),
        .o_mean_ns     (o_mean_ns),
        .o_max_ns      (o_max_ns),
        .o_status      (o_status),
        .o_last        (o_last)
    );

    // A request is never taken while a report is being delivered.
    `LSH_ASSERT(a_no_overlap, i_clk, i_rst_n, o_in_ready |-> !o_out_valid, "request taken during report")

    // A record beat with room left grows the sample count by one.
    `LSH_ASSERT(a_count_step, i_clk, i_rst_n, (i_in_valid && o_in_ready && (i_req_type == REQ_RECORD) && (dp_sts.count != CNT_W'(HIST_DEPTH))) |=> (dp_sts.count == CNT_W'($past(dp_sts.count) + 1'b1)), "sample count did not advance")

    // The final beat of a report clears the statistics.
    `LSH_ASSERT(a_clear_after_last, i_clk, i_rst_n, (o_out_valid && i_out_ready && o_last) |=> (dp_sts.count == '0), "statistics not cleared after report")

    // Reset leaves no result beat pending.
    `LSH_ASSERT_ALWAYS(a_reset_quiet, i_clk, (!i_rst_n) |=> !o_out_valid, "result valid after reset")

endmodule
